@@ sv/stlb_pkg.sv @@
// ----------------------------------------------------------------------------
// stlb_pkg: shared types and constants of the server table load balancer
// Holds the table geometry, request and status codes and the controller
// to datapath command and status structs.
// ----------------------------------------------------------------------------
package stlb_pkg;

	localparam int MaxServers = 16;
	localparam int SlotW      = $clog2(MaxServers);
	localparam int BoundW     = SlotW + 1;
	localparam int UsersW     = 24;
	localparam logic [UsersW-1:0] UsersMax = {UsersW{1'b1}};
	localparam logic [31:0] HashSeed = 32'd5381;
	localparam logic [15:0] MarginReset = 16'd50;

	typedef enum logic [2:0] {
		KIND_REGISTER   = 3'd0,
		KIND_REPORT     = 3'd1,
		KIND_DISCONNECT = 3'd2,
		KIND_ALLOCATE   = 3'd3,
		KIND_ADD_USER   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_MOD,
		S_SCAN,
		S_DONE,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;     // capture input item, reset scan and hash
		logic hash_step;
		logic mod_step;
		logic scan_step;
		logic finish;   // apply update and build result
	} cmd_t;

	typedef struct packed {
		logic hash_done;
		logic mod_done;
		logic scan_done;
	} sts_t;

endpackage

@@ sv/stlb_ctrl.sv @@
// ----------------------------------------------------------------------------
// stlb_ctrl: request sequencer
// Steps each item through hashing, reduction, table scan and result.
// ----------------------------------------------------------------------------
module stlb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output stlb_pkg::cmd_t  cmd,
	input  stlb_pkg::sts_t  sts
);
	import stlb_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_HASH;
			S_HASH: if (sts.hash_done) state_d = S_MOD;
			S_MOD:  if (sts.mod_done) state_d = S_SCAN;
			S_SCAN: if (sts.scan_done) state_d = S_DONE;
			S_DONE: state_d = S_OUT;
			S_OUT:  if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_HASH: cmd.hash_step = 1'b1;
			S_MOD:  cmd.mod_step = 1'b1;
			S_SCAN: cmd.scan_step = 1'b1;
			S_DONE: cmd.finish = 1'b1;
			S_OUT:  out_valid = 1'b1;
			default: ;
		endcase
	end

endmodule

@@ sv/stlb_datapath.sv @@
// ----------------------------------------------------------------------------
// stlb_datapath: server table and request arithmetic
// Holds the table, a byte-serial hash, a restoring modulo unit and a
// one-slot-per-cycle scan, and builds the result item.
// ----------------------------------------------------------------------------
module stlb_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  stlb_pkg::cmd_t              cmd,
	output stlb_pkg::sts_t              sts,
	input  logic                        cfg_valid,
	input  logic [15:0]                 cfg_data,
	input  logic [2:0]                  kind,
	input  logic [15:0]                 conn_handle,
	input  logic [31:0]                 server_addr,
	input  logic [15:0]                 server_port_in,
	input  logic [stlb_pkg::UsersW-1:0] reported_users,
	input  logic [31:0]                 user_key,
	output logic [1:0]                  status,
	output logic [31:0]                 chosen_addr,
	output logic [15:0]                 chosen_port,
	output logic [stlb_pkg::SlotW-1:0]  slot_id
);
	import stlb_pkg::*;

	// Table. Entry id equals slot index, so no id store is needed.
	logic [MaxServers-1:0] valid_q;
	logic [15:0]           handle_q [MaxServers];
	logic [31:0]           addr_q   [MaxServers];
	logic [15:0]           port_q   [MaxServers];
	logic [UsersW-1:0]     users_q  [MaxServers];
	logic [BoundW-1:0]     bound_q;
	logic [15:0]           margin_q;

	// Captured request.
	logic [2:0]        kind_q;
	logic [15:0]       handle_in_q;
	logic [31:0]       addr_in_q;
	logic [15:0]       port_in_q;
	logic [UsersW-1:0] rep_q;
	logic [31:0]       key_q;

	// Hash and modulo.
	logic [31:0] hash_q;
	logic [1:0]  byte_q;
	logic [31:0] quot_q;      // dividend bits shifted out
	logic [BoundW-1:0] rem_q;
	logic [5:0]  mbit_q;

	// Scan.
	logic [SlotW:0]   idx_q;
	logic             found_q, pick_ok_q, first_ok_q, least_ok_q;
	logic [SlotW-1:0] found_i_q, pick_i_q, first_i_q, least_i_q, free_i_q;
	logic             free_ok_q, above_q;
	logic [MaxServers-1:0] match_q;

	logic [SlotW-1:0] ix;
	logic [7:0]       kbyte;
	logic [BoundW:0]  rem_sh;

	// Result of the finished request.
	logic [SlotW-1:0] sel_i;
	logic [1:0]       res_status;
	logic [31:0]      res_addr;
	logic [15:0]      res_port;
	logic [SlotW-1:0] res_slot;

	assign ix = idx_q[SlotW-1:0];
	assign kbyte = key_q[8*byte_q +: 8];
	assign rem_sh = {rem_q, quot_q[31]};

	assign sts.hash_done = (byte_q == 2'd3);
	assign sts.mod_done  = (mbit_q == 6'd31) || (bound_q == '0);
	assign sts.scan_done = (idx_q == (SlotW+1)'(MaxServers - 1));

	always_comb begin
		sel_i = pick_ok_q ? pick_i_q : first_i_q;
		if (25'(users_q[sel_i]) > 25'(users_q[least_i_q]) + 25'(margin_q))
			sel_i = least_i_q;
		res_status = ST_NOTFOUND;
		res_addr = '0;
		res_port = '0;
		res_slot = '0;
		unique case (kind_q) inside
			KIND_REGISTER: begin
				if (free_ok_q) begin
					res_status = ST_OK;
					res_slot = free_i_q;
				end else res_status = ST_FULL;
			end
			KIND_REPORT, KIND_DISCONNECT, KIND_ADD_USER: if (found_q) res_status = ST_OK;
			KIND_ALLOCATE: if (first_ok_q) begin
				res_status = ST_OK;
				res_addr = addr_q[sel_i];
				res_port = port_q[sel_i];
				res_slot = sel_i;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			bound_q <= '0;
			margin_q <= MarginReset;
		end else begin
			if (cfg_valid) margin_q <= cfg_data;
			if (cmd.finish) begin
				unique case (kind_q)
					KIND_REGISTER: if (free_ok_q) begin
						valid_q[free_i_q] <= 1'b1;
						if (above_q) bound_q <= BoundW'(free_i_q) + 1'b1;
					end
					KIND_DISCONNECT: if (found_q) valid_q[found_i_q] <= 1'b0;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			handle_in_q <= conn_handle;
			addr_in_q <= server_addr;
			port_in_q <= server_port_in;
			rep_q <= reported_users;
			key_q <= user_key;
			hash_q <= HashSeed;
			byte_q <= '0;
			mbit_q <= '0;
			rem_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0; pick_ok_q <= 1'b0; first_ok_q <= 1'b0;
			least_ok_q <= 1'b0; free_ok_q <= 1'b0; above_q <= 1'b1;
			match_q <= '0;
		end
		if (cmd.hash_step) begin
			hash_q <= (hash_q << 5) + hash_q + 32'(kbyte);
			byte_q <= byte_q + 1'b1;
			quot_q <= (hash_q << 5) + hash_q + 32'(kbyte);
		end
		if (cmd.mod_step && bound_q != '0) begin
			// Restoring reduction, one dividend bit per cycle.
			if (rem_sh >= {1'b0, bound_q}) rem_q <= BoundW'(rem_sh - {1'b0, bound_q});
			else rem_q <= rem_sh[BoundW-1:0];
			quot_q <= quot_q << 1;
			mbit_q <= mbit_q + 1'b1;
		end
		if (cmd.scan_step) begin
			idx_q <= idx_q + 1'b1;
			if (valid_q[ix]) begin
				if (handle_q[ix] == handle_in_q) begin
					match_q[ix] <= 1'b1;
					if (!found_q) begin
						found_q <= 1'b1;
						found_i_q <= ix;
					end
				end
				if (!first_ok_q) begin
					first_ok_q <= 1'b1;
					first_i_q <= ix;
				end
				if (!pick_ok_q && {1'b0, ix} >= rem_q) begin
					pick_ok_q <= 1'b1;
					pick_i_q <= ix;
				end
				if (!least_ok_q || users_q[least_i_q] >= users_q[ix]) begin
					least_ok_q <= 1'b1;
					least_i_q <= ix;
				end
				if (free_ok_q) above_q <= 1'b0;
			end else if (!free_ok_q) begin
				free_ok_q <= 1'b1;
				free_i_q <= ix;
			end
		end
		if (cmd.finish) begin
			status <= res_status;
			chosen_addr <= res_addr;
			chosen_port <= res_port;
			slot_id <= res_slot;
			unique case (kind_q)
				KIND_REGISTER: if (free_ok_q) begin
					handle_q[free_i_q] <= handle_in_q;
					addr_q[free_i_q] <= addr_in_q;
					port_q[free_i_q] <= port_in_q;
					users_q[free_i_q] <= '0;
				end
				KIND_REPORT: if (found_q) users_q[found_i_q] <= rep_q;
				KIND_ADD_USER: begin
					for (int i = 0; i < MaxServers; i++)
						if (match_q[i] && users_q[i] != UsersMax)
							users_q[i] <= users_q[i] + 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule

@@ sv/server_table_load_balancer.sv @@
// ----------------------------------------------------------------------------
// server_table_load_balancer: top level
// Server table with hashed placement and least-loaded fallback.
// ----------------------------------------------------------------------------
// Requests enter on s_axis (tdata: kind, conn_handle, server_addr,
// server_port_in, reported_users, user_key from bit 0 up). One result per
// request leaves on m_axis (tdata: status, chosen_addr, chosen_port, slot_id).
// The margin register is written on cfg_valid/cfg_ready; the user must write it
// only while idle, which the block itself does not enforce. One item is in
// flight at a time. An item passes through the byte-serial hash, the bit-serial
// modulo unit (which does no work when no server was ever appended), the scan
// of the 16 slots and the result state before m_axis_tvalid rises, and the next
// request is accepted only after the result is taken. The modulo unit and the
// scan over the 16 slots take most of an item's time.
// Reset clears the table and sets the margin to 50. While m_axis_tready is
// low the result is held and no new request is accepted.
// ----------------------------------------------------------------------------
module server_table_load_balancer (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// kind[2:0], conn_handle[18:3], server_addr[50:19], server_port_in[66:51],
	// reported_users[90:67], user_key[122:91], zero fill
	input  logic [127:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status[1:0], chosen_addr[33:2], chosen_port[49:34], slot_id[53:50], zero fill
	output logic [55:0]  m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data
);
	import stlb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;
	assign m_axis_tdata[55:54] = '0;

	stlb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.cmd(cmd), .sts(sts)
	);

	stlb_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_valid(cfg_valid), .cfg_data(cfg_data),
		.kind(s_axis_tdata[2:0]),
		.conn_handle(s_axis_tdata[18:3]),
		.server_addr(s_axis_tdata[50:19]),
		.server_port_in(s_axis_tdata[66:51]),
		.reported_users(s_axis_tdata[90:67]),
		.user_key(s_axis_tdata[122:91]),
		.status(m_axis_tdata[1:0]),
		.chosen_addr(m_axis_tdata[33:2]),
		.chosen_port(m_axis_tdata[49:34]),
		.slot_id(m_axis_tdata[53:50])
	);

	// Unused input bits above the last field.
	logic unused_fill;
	assign unused_fill = ^s_axis_tdata[127:123];

endmodule

@@ sv/stlb_checker.sv @@
// ----------------------------------------------------------------------------
// stlb_checker: port-level checks
// Watches the request and result channels of the balancer.
// ----------------------------------------------------------------------------
module stlb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata
);
	// A result held back keeps its data.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// Only one item is in flight.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("request taken while a result waits");

	// An accepted request never yields a result in the next cycle.
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid && !s_axis_tready)
		else $error("result too early");

	// Status is never an undefined code.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
		else $error("bad status code");

endmodule

bind server_table_load_balancer stlb_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
